/* design/crc8fr_pkg.sv */
// Package for the CRC-8 checked frame receiver: status codes, frame layout
// constants and the byte-wide Dallas CRC-8 update. No dependencies.
package crc8fr_pkg;

	localparam int POS_W = 4;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] CRC_POLY  = 8'h8C;   // reflected 0x31

	// frame layout: bytes 0..1 sync, 0..9 covered by CRC, 10 check, 4..9 payload
	localparam logic [POS_W-1:0] SYNC_END      = POS_W'(2);
	localparam logic [POS_W-1:0] CRC_END       = POS_W'(10);
	localparam logic [POS_W-1:0] CHECK_POS     = POS_W'(10);
	localparam logic [POS_W-1:0] PAYLOAD_FIRST = POS_W'(4);
	localparam int               PAYLOAD_COUNT = 6;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SYNC = 2'd1,
		ST_BAD_CRC  = 2'd2
	} frame_status_t;

	// one byte through the reflected CRC-8, lsb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/crc8_checked_frame_receiver_top.sv */
// Fixed-length frame receiver with Dallas CRC-8 check; uses crc8fr_pkg.
// Bytes are counted into frames of FRAME_BYTES from reset, with no resync.
// Each accepted byte lands in an input register and is folded into the
// frame state from there (sync check, byte-wide CRC, payload capture).
// The last byte of a frame loads the result register from the input
// register once the previous result is read. One byte per cycle is
// sustained; the input stalls only when a last byte finds the previous
// result still unread. Payload fields are zero unless the status is ok.
// Sync errors take precedence over checksum errors.
module crc8_checked_frame_receiver_top #(
	parameter int FRAME_BYTES = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_ready,
	input  logic [7:0]                   rx_byte,
	output logic                         res_valid,
	input  logic                         res_ready,
	output crc8fr_pkg::frame_status_t    frame_status,
	output logic [7:0]                   throttle_code,
	output logic [7:0]                   steering_code,
	output logic signed [15:0]           tilt_x,
	output logic signed [15:0]           tilt_y
);
	import crc8fr_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// frame state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic             sync_q;
	logic [7:0]       check_q;
	logic [7:0]       payload_q [PAYLOAD_COUNT];

	// result register
	logic                res_valid_q;
	frame_status_t       status_q;
	logic [7:0]          throttle_q;
	logic [7:0]          steering_q;
	logic signed [15:0]  tilt_x_q;
	logic signed [15:0]  tilt_y_q;

	logic          is_last;
	logic          advance;
	logic [7:0]    crc_next;
	logic          sync_next;
	logic [7:0]    check_next;
	frame_status_t status_next;

	assign is_last  = (pos_q >= LAST_POS);
	assign advance  = valid_s1 && (!is_last || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || advance;

	always_comb begin
		crc_next   = (pos_q < CRC_END) ? crc8_update(crc_q, byte_s1) : crc_q;
		sync_next  = sync_q && !((pos_q < SYNC_END) && (byte_s1 != SYNC_BYTE));
		check_next = (pos_q == CHECK_POS) ? byte_s1 : check_q;
		priority if (!sync_next) begin
			status_next = ST_BAD_SYNC;
		end else if (crc_next != check_next) begin
			status_next = ST_BAD_CRC;
		end else begin
			status_next = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= '0;
			sync_q <= 1'b1;
		end else if (advance) begin
			if (is_last) begin
				pos_q  <= '0;
				crc_q  <= '0;
				sync_q <= 1'b1;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				crc_q  <= crc_next;
				sync_q <= sync_next;
			end
		end
	end

	// check and payload bytes are always rewritten before a frame ends
	always_ff @(posedge clk) begin
		if (advance) begin
			check_q <= check_next;
			for (int j = 0; j < PAYLOAD_COUNT; j++) begin
				if (pos_q == PAYLOAD_FIRST + POS_W'(j)) begin
					payload_q[j] <= byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			status_q <= status_next;
			if (status_next == ST_OK) begin
				throttle_q <= payload_q[0];
				steering_q <= payload_q[1];
				tilt_x_q   <= {payload_q[2], payload_q[3]};
				tilt_y_q   <= {payload_q[4], payload_q[5]};
			end else begin
				throttle_q <= '0;
				steering_q <= '0;
				tilt_x_q   <= '0;
				tilt_y_q   <= '0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign frame_status  = status_q;
	assign throttle_code = throttle_q;
	assign steering_code = steering_q;
	assign tilt_x        = tilt_x_q;
	assign tilt_y        = tilt_y_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("frame position past last byte");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_status != ST_OK) |->
		(throttle_code == 8'd0 && steering_code == 8'd0 && tilt_x == 16'sd0 &&
		 tilt_y == 16'sd0))
		else $error("payload not cleared on bad frame");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_last) |=> (pos_q == $past(pos_q) + POS_W'(1)))
		else $error("position did not step");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (valid_s1 && is_last && res_valid_q && !res_ready))
		else $error("input stalled without a blocked result");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last) |=> (pos_q == '0 && crc_q == 8'd0 && sync_q && res_valid_q))
		else $error("frame end did not restart state");
`endif

endmodule

/* tb/crc8_checked_frame_receiver_top_test.sv */
// Self-checking bench for crc8_checked_frame_receiver_top: byte stream in, one
// frame result out per FRAME_LEN bytes, checked against an in-bench frame predictor.
// Depends on crc8fr_pkg and the design top only.
module crc8_checked_frame_receiver_top_test;
	import crc8fr_pkg::*;

	localparam int FRAME_LEN    = 11;
	localparam int RAND_FRAMES  = 138;
	localparam int TAIL_FRAMES  = 15;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 20;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		frame_status_t      status;
		logic [7:0]         throttle;
		logic [7:0]         steering;
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
	} frame_result_t;

	typedef struct {
		logic [7:0] data;
		int         idle;
		bit         drain;
	} byte_req_t;

	typedef enum int {
		FK_GOOD,
		FK_BAD_SYNC,
		FK_BAD_CRC,
		FK_NOISE
	} frame_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               res_valid;
	logic               res_ready = 1'b0;
	frame_status_t      frame_status;
	logic [7:0]         throttle_code;
	logic [7:0]         steering_code;
	logic signed [15:0] tilt_x;
	logic signed [15:0] tilt_y;

	crc8_checked_frame_receiver_top #(
		.FRAME_BYTES(FRAME_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.frame_status(frame_status),
		.throttle_code(throttle_code),
		.steering_code(steering_code),
		.tilt_x(tilt_x),
		.tilt_y(tilt_y)
	);

	always #5 clk = ~clk;

	// stimulus and expectations
	byte_req_t     rx_pending[$];
	frame_result_t frames_due[$];
	logic [7:0]    frame_buf[FRAME_LEN];

	// predictor state
	logic [POS_W-1:0] fr_pos = '0;
	logic [7:0]       fr_crc = 8'h00;
	logic             fr_sync_ok = 1'b1;
	logic [7:0]       fr_check = 8'h00;
	logic [7:0]       fr_payload[PAYLOAD_COUNT] = '{default: 8'h00};

	logic rx_took = 1'b0;
	logic long_hold = 1'b0;
	logic tail_run = 1'b0;
	int   rx_wait = 0;
	int   res_stall = 0;
	int   cyc_cnt = 0;
	int   bytes_sent = 0;
	int   frames_checked = 0;
	int   n_good = 0;
	int   n_bad_sync = 0;
	int   n_bad_crc = 0;
	int   err_count = 0;

	// Dallas CRC-8, one bit at a time, lsb first
	function automatic logic [7:0] crc8_dallas_next(input logic [7:0] crc,
			input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ data[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// leans toward the byte values that make the payload fields extreme
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12) return 8'h00;
		if (r < 24) return 8'hFF;
		if (r < 32) return 8'h80;
		if (r < 40) return 8'h7F;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] non_sync_byte();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == SYNC_BYTE) b = 8'($urandom);
		return b;
	endfunction

	// check byte = CRC over the covered bytes currently in frame_buf
	function automatic logic [7:0] frame_crc();
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < int'(CRC_END); i++) c = crc8_dallas_next(c, frame_buf[i]);
		return c;
	endfunction

	task automatic queue_frame(input bit drain, input bit quiet);
		byte_req_t q;
		for (int i = 0; i < FRAME_LEN; i++) begin
			q.data = frame_buf[i];
			q.drain = drain && (i == 0);
			q.idle = 0;
			if (!quiet && $urandom_range(0, 99) < 20) q.idle = $urandom_range(1, 9);
			rx_pending.push_back(q);
		end
	endtask

	task automatic build_frame(input frame_kind_t kind);
		int unsigned pick;
		for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = pick_byte();
		if (kind == FK_NOISE) return;
		frame_buf[0] = SYNC_BYTE;
		frame_buf[1] = SYNC_BYTE;
		if (kind == FK_BAD_SYNC) begin
			pick = $urandom_range(0, 2);
			if (pick != 1) frame_buf[0] = non_sync_byte();
			if (pick != 0) frame_buf[1] = non_sync_byte();
		end
		frame_buf[CHECK_POS] = frame_crc();
		// bad sync comes with a good or a bad check byte
		if (kind == FK_BAD_CRC || (kind == FK_BAD_SYNC && $urandom_range(0, 1) == 1)) begin
			frame_buf[CHECK_POS] = frame_buf[CHECK_POS] ^ 8'($urandom_range(1, 255));
		end
	endtask

	// fold one accepted byte into the predicted frame state
	task automatic absorb_byte(input logic [7:0] b);
		frame_result_t r;
		if (fr_pos < SYNC_END && b != SYNC_BYTE) fr_sync_ok = 1'b0;
		if (fr_pos < CRC_END) fr_crc = crc8_dallas_next(fr_crc, b);
		if (fr_pos == CHECK_POS) fr_check = b;
		if (fr_pos >= PAYLOAD_FIRST && fr_pos < PAYLOAD_FIRST + PAYLOAD_COUNT) begin
			fr_payload[3'(fr_pos - PAYLOAD_FIRST)] = b;
		end
		if (int'(fr_pos) < FRAME_LEN - 1) begin
			fr_pos = fr_pos + 1'b1;
		end else begin
			r = '0;
			if (!fr_sync_ok) begin
				r.status = ST_BAD_SYNC;
			end else if (fr_crc != fr_check) begin
				r.status = ST_BAD_CRC;
			end else begin
				r.status = ST_OK;
				r.throttle = fr_payload[0];
				r.steering = fr_payload[1];
				r.tilt_x = {fr_payload[2], fr_payload[3]};
				r.tilt_y = {fr_payload[4], fr_payload[5]};
			end
			frames_due.push_back(r);
			fr_pos = '0;
			fr_crc = 8'h00;
			fr_sync_ok = 1'b1;
			fr_check = 8'h00;
			for (int i = 0; i < PAYLOAD_COUNT; i++) fr_payload[i] = 8'h00;
		end
	endtask

	task automatic note_failure(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_result();
		frame_result_t want;
		frame_result_t got;
		got = {frame_status, throttle_code, steering_code, tilt_x, tilt_y};
		if (frames_due.size() == 0) begin
			note_failure($sformatf("result with no frame pending: status %0d thr %0d str %0d x %0d y %0d",
				got.status, got.throttle, got.steering, got.tilt_x, got.tilt_y));
			return;
		end
		want = frames_due.pop_front();
		case (want.status)
			ST_OK:       n_good++;
			ST_BAD_SYNC: n_bad_sync++;
			default:     n_bad_crc++;
		endcase
		if (got.status !== want.status || got.throttle !== want.throttle ||
				got.steering !== want.steering || got.tilt_x !== want.tilt_x ||
				got.tilt_y !== want.tilt_y) begin
			note_failure($sformatf({"frame %0d: expected status %0d thr %0d str %0d x %0d y %0d,",
				" got status %0d thr %0d str %0d x %0d y %0d"}, frames_checked,
				want.status, want.throttle, want.steering, want.tilt_x, want.tilt_y,
				got.status, got.throttle, got.steering, got.tilt_x, got.tilt_y));
		end
		frames_checked++;
	endtask

	// monitor: everything is sampled at the rising edge
	always @(posedge clk) begin
		rx_took <= rx_valid && rx_ready;
		if (arst_n) begin
			cyc_cnt <= cyc_cnt + 1;
			if (rx_valid && rx_ready) absorb_byte(rx_byte);
			if (res_valid && res_ready) check_result();
		end
	end

	// byte sender
	always @(negedge clk) begin : rx_drive
		logic      hold_valid;
		logic      launch;
		byte_req_t nxt;
		hold_valid = rx_valid && !rx_took;
		launch = 1'b0;
		if (arst_n && !hold_valid) begin
			if (rx_wait > 0) begin
				rx_wait--;
			end else if (rx_pending.size() > 0 && rx_pending[0].idle > 0) begin
				rx_wait = rx_pending[0].idle - 1;
				rx_pending[0].idle = 0;
			end else if (rx_pending.size() > 0 &&
					!(rx_pending[0].drain && frames_due.size() != 0)) begin
				nxt = rx_pending.pop_front();
				rx_byte <= nxt.data;
				launch = 1'b1;
				bytes_sent++;
			end
		end
		rx_valid <= hold_valid || launch;
		tail_run <= rx_pending.size() <= TAIL_FRAMES * FRAME_LEN;
	end

	// result receiver: random stall bursts, calm stretches, none in the tail
	always @(negedge clk) begin : res_drive
		logic calm;
		calm = cyc_cnt[9:8] == 2'd0;
		if (res_stall > 0) begin
			res_stall--;
		end else if (arst_n && !tail_run && !calm && $urandom_range(0, 99) < 15) begin
			res_stall = $urandom_range(1, 9);
		end
		res_ready <= arst_n && !long_hold && res_stall == 0;
	end

	// one long hold-off so the block backs up and stalls its input
	initial begin
		while (frames_checked < 20) @(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#4000000;
		$display("crc8_checked_frame_receiver_top test failed");
		$finish;
	end

	initial begin
		frame_kind_t kind;
		int unsigned r;

		// good frame with every payload field at an extreme
		frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00};
		frame_buf[CHECK_POS] = frame_crc();
		queue_frame(1'b0, 1'b1);
		// second sync byte wrong and check byte wrong: sync error wins
		frame_buf = '{SYNC_BYTE, 8'hAA, 8'h12, 8'h34, 8'h01, 8'h02,
			8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00};
		frame_buf[CHECK_POS] = frame_crc() ^ 8'h01;
		queue_frame(1'b0, 1'b1);
		// sync fine, all-zero payload, check byte off by one bit
		frame_buf = '{SYNC_BYTE, SYNC_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		frame_buf[CHECK_POS] = frame_crc() ^ 8'h80;
		queue_frame(1'b0, 1'b1);

		for (int f = 0; f < RAND_FRAMES; f++) begin
			r = $urandom_range(0, 99);
			if (r < 55) kind = FK_GOOD;
			else if (r < 70) kind = FK_BAD_SYNC;
			else if (r < 85) kind = FK_BAD_CRC;
			else kind = FK_NOISE;
			build_frame(kind);
			// some frames wait for all results to drain first
			queue_frame(f == 40 || f == 80 || f == 120,
				(f % 4 == 3) || (f >= RAND_FRAMES - TAIL_FRAMES));
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() != 0 || rx_valid) @(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d bytes; checked %0d frame results: %0d good, %0d bad sync, %0d bad checksum.",
			bytes_sent, frames_checked, n_good, n_bad_sync, n_bad_crc);
		$display("Stimulus had sender gaps, receiver stalls, a %0d-cycle hold-off and drain pauses; %0d failures.",
			LONG_HOLD, err_count);
		if (err_count == 0 && frames_due.size() == 0) begin
			$display("crc8_checked_frame_receiver_top test passed");
		end else begin
			$display("crc8_checked_frame_receiver_top test failed");
		end
		$finish;
	end

endmodule
